// File: hw/rtl/sdfc_pkg.sv
// Package for the SPI downlink frame checker.
// Holds the frame header offsets, register indexes and the shared types.
// No dependencies; sdfc_regs and the top level refer to it by scoped names.
package sdfc_pkg;

    // Header layout of a receive transfer.
    localparam int unsigned POS_STATUS   = 0;
    localparam int unsigned POS_LEN_HI   = 1;
    localparam int unsigned POS_LEN_LO   = 2;
    localparam int unsigned POS_SUM_HI   = 3;
    localparam int unsigned POS_SUM_LO   = 4;
    localparam int unsigned POS_SEQ_HI   = 5;
    localparam int unsigned POS_SEQ_LO   = 6;
    localparam int unsigned CFG_HDR      = 3;
    localparam int unsigned DATA_HDR     = 7;
    localparam int unsigned DATA_LEN_LIM = 512;

    // Register map, indexed by paddr[3:2].
    localparam int unsigned PADDR_W = 4;
    localparam logic [1:0] REG_CFG_CODE  = 2'd0;
    localparam logic [1:0] REG_DATA_MASK = 2'd1;
    localparam logic [1:0] REG_CFG_LIMIT = 2'd2;

    localparam logic [7:0] RST_CFG_CODE  = 8'd1;
    localparam logic [7:0] RST_DATA_MASK = 8'd128;
    localparam logic [8:0] RST_CFG_LIMIT = 9'd256;

    typedef struct packed {
        logic [7:0] cfg_code;
        logic [7:0] data_mask;
        logic [8:0] cfg_limit;
    } t_cfg;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_CFG  = 2'd1,
        KIND_DATA = 2'd2
    } t_kind;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        byte_kind;
        logic        last_in_frame;
        logic        checksum_ok;
        logic [15:0] seq_gap;
        logic [31:0] seq_missing_total;
        logic [31:0] checksum_bad_total;
    } t_result;

endpackage

// File: hw/rtl/sdfc_if.sv
// Valid/ready channel interfaces of the SPI downlink frame checker.
// sdfc_rx_if carries received bytes, sdfc_res_if carries payload results.
// No dependencies.
interface sdfc_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       transfer_start;

    modport source (output valid, output rx_byte, output transfer_start, input ready);
    modport sink   (input valid, input rx_byte, input transfer_start, output ready);
endinterface

interface sdfc_res_if;
    logic        valid;
    logic        ready;
    logic [7:0]  payload_byte;
    logic        byte_kind;
    logic        last_in_frame;
    logic        checksum_ok;
    logic [15:0] seq_gap;
    logic [31:0] seq_missing_total;
    logic [31:0] checksum_bad_total;

    modport source (
        output valid, output payload_byte, output byte_kind, output last_in_frame,
        output checksum_ok, output seq_gap, output seq_missing_total,
        output checksum_bad_total, input ready
    );
    modport sink (
        input valid, input payload_byte, input byte_kind, input last_in_frame,
        input checksum_ok, input seq_gap, input seq_missing_total,
        input checksum_bad_total, output ready
    );
endinterface

// File: hw/rtl/sdfc_regs.sv
// APB-style configuration registers of the SPI downlink frame checker.
// Depends on sdfc_pkg for the register map, reset values and t_cfg.
module sdfc_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sdfc_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output sdfc_pkg::t_cfg               o_cfg
);

    sdfc_pkg::t_cfg r_cfg;
    logic           wr_en;
    logic [1:0]     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cfg_code  <= sdfc_pkg::RST_CFG_CODE;
            r_cfg.data_mask <= sdfc_pkg::RST_DATA_MASK;
            r_cfg.cfg_limit <= sdfc_pkg::RST_CFG_LIMIT;
        end else if (wr_en) begin
            case (reg_idx)
                sdfc_pkg::REG_CFG_CODE:  r_cfg.cfg_code  <= pwdata[7:0];
                sdfc_pkg::REG_DATA_MASK: r_cfg.data_mask <= pwdata[7:0];
                sdfc_pkg::REG_CFG_LIMIT: r_cfg.cfg_limit <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            sdfc_pkg::REG_CFG_CODE:  prdata = {24'd0, r_cfg.cfg_code};
            sdfc_pkg::REG_DATA_MASK: prdata = {24'd0, r_cfg.data_mask};
            sdfc_pkg::REG_CFG_LIMIT: prdata = {23'd0, r_cfg.cfg_limit};
            default:                 prdata = 32'd0;
        endcase
    end

endmodule

// File: hw/rtl/spi_downlink_frame_checker.sv
// Top level of the SPI downlink frame checker.
// Depends on sdfc_pkg, the channel interfaces in sdfc_if.sv and sdfc_regs.
//
// Usage: received SPI bytes enter on i_rx, one request per byte, with
// transfer_start marking byte 0 of a transfer. After TRANSFER_BYTES bytes the
// next byte starts a new transfer on its own. Byte 0 is the status, bytes 1-2
// the big-endian length. A config frame passes its payload from offset 3; a
// data frame carries a checksum and sequence number in bytes 3-6 and passes its
// payload from offset 7, with sequence gap and checksum totals attached.
// Each payload byte leaves on o_res as one request; header bytes and bytes of
// ignored frames give none.
// Timing: every byte is decoded in the cycle it is accepted and its result is
// held in an output register, so a result appears in the cycle after its byte.
// One byte is accepted per cycle; the output register decouples the sides, and
// a byte is taken whenever that register is empty or being emptied. When the
// receiver stalls, the result is held and input stops while it waits, even
// for bytes that would give no result of their own.
// Reset (synchronous, active low) clears the position, frame state, the sequence
// history and both totals, and restores the register defaults. The user must write
// registers through the APB-style port while the block is idle; nothing enforces it.
module spi_downlink_frame_checker #(
    parameter int unsigned TRANSFER_BYTES = 512
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    sdfc_rx_if.sink                      i_rx,
    sdfc_res_if.source                   o_res,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sdfc_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    // The position counter must hold TRANSFER_BYTES itself.
    localparam int unsigned PW = $clog2(TRANSFER_BYTES + 1);
    localparam logic [PW-1:0] TB_POS = PW'(TRANSFER_BYTES);
    localparam logic [16:0]   TB_17  = 17'(TRANSFER_BYTES);

    sdfc_pkg::t_cfg cfg;

    sdfc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Frame state.
    logic [PW-1:0]       r_pos,      n_pos;
    logic [7:0]          r_status,   n_status;
    logic [15:0]         r_len,      n_len;
    logic [15:0]         r_rx_sum,   n_rx_sum;
    logic [15:0]         r_rx_seq,   n_rx_seq;
    logic [15:0]         r_run_sum,  n_run_sum;
    logic [15:0]         r_prev_seq, n_prev_seq;
    logic                r_seq_seen, n_seq_seen;
    logic [31:0]         r_missing,  n_missing;
    logic [31:0]         r_bad,      n_bad;
    sdfc_pkg::t_kind     r_kind,     n_kind;
    logic [15:0]         r_gap,      n_gap;

    // Output register.
    logic                r_out_valid, n_out_valid;
    sdfc_pkg::t_result   r_res,       n_res;

    logic                accept;
    logic                emit;
    logic [7:0]          b;
    logic [PW-1:0]       p;
    logic [16:0]         p17;
    logic [16:0]         cfg_end;
    logic [16:0]         data_end;
    logic [15:0]         len_full;
    logic [15:0]         seq_full;
    logic [15:0]         gap;
    logic [15:0]         run_next;
    logic                is_last;

    assign i_rx.ready = !r_out_valid || o_res.ready;
    assign accept     = i_rx.valid && i_rx.ready;
    assign b          = i_rx.rx_byte;

    // A forced restart or an overrun both place this byte at offset zero.
    assign p        = (i_rx.transfer_start || (r_pos >= TB_POS)) ? '0 : r_pos;
    assign p17      = 17'(p);
    assign cfg_end  = {1'b0, r_len} + 17'(sdfc_pkg::CFG_HDR - 1);
    assign data_end = {1'b0, r_len} + 17'(sdfc_pkg::DATA_HDR - 1);
    assign len_full = {r_len[15:8], b};
    assign seq_full = {r_rx_seq[15:8], b};
    assign gap      = r_seq_seen ? (seq_full - (r_prev_seq + 16'd1)) : 16'd0;
    assign run_next = r_run_sum + {8'd0, b};

    always_comb begin
        n_pos      = p + PW'(1);
        n_status   = r_status;
        n_len      = r_len;
        n_rx_sum   = r_rx_sum;
        n_rx_seq   = r_rx_seq;
        n_run_sum  = r_run_sum;
        n_prev_seq = r_prev_seq;
        n_seq_seen = r_seq_seen;
        n_missing  = r_missing;
        n_bad      = r_bad;
        n_kind     = r_kind;
        n_gap      = r_gap;
        emit       = 1'b0;
        is_last    = 1'b0;
        n_res.payload_byte       = b;
        n_res.byte_kind          = 1'b0;
        n_res.last_in_frame      = 1'b0;
        n_res.checksum_ok        = 1'b0;
        n_res.seq_gap            = 16'd0;
        n_res.seq_missing_total  = r_missing;
        n_res.checksum_bad_total = r_bad;

        if (p == PW'(sdfc_pkg::POS_STATUS)) begin
            n_status  = b;
            n_len     = 16'd0;
            n_rx_sum  = 16'd0;
            n_rx_seq  = 16'd0;
            n_run_sum = 16'd0;
            n_kind    = sdfc_pkg::KIND_NONE;
            n_gap     = 16'd0;
        end else if (p == PW'(sdfc_pkg::POS_LEN_HI)) begin
            n_len = {b, 8'd0};
        end else if (p == PW'(sdfc_pkg::POS_LEN_LO)) begin
            n_len = len_full;
            // The config test is made here, with the registers as they stand now.
            if ((r_status == cfg.cfg_code) && (len_full != 16'd0) &&
                (len_full < {7'd0, cfg.cfg_limit}) &&
                (({1'b0, len_full} + 17'(sdfc_pkg::CFG_HDR)) <= TB_17)) begin
                n_kind = sdfc_pkg::KIND_CFG;
            end
        end else if (r_kind == sdfc_pkg::KIND_CFG) begin
            if (p17 <= cfg_end) begin
                emit                = 1'b1;
                n_res.byte_kind     = 1'b1;
                n_res.last_in_frame = (p17 == cfg_end);
            end
        end else if (p < PW'(sdfc_pkg::DATA_HDR)) begin
            if (p == PW'(sdfc_pkg::POS_SUM_HI)) begin
                n_rx_sum = {b, 8'd0};
            end else if (p == PW'(sdfc_pkg::POS_SUM_LO)) begin
                n_rx_sum = {r_rx_sum[15:8], b};
            end else if (p == PW'(sdfc_pkg::POS_SEQ_HI)) begin
                n_rx_seq = {b, 8'd0};
            end else begin
                n_rx_seq = seq_full;
                // Data test and sequence check happen on the last header byte.
                if ((r_kind == sdfc_pkg::KIND_NONE) && (r_status != cfg.cfg_code) &&
                    ((r_status & cfg.data_mask) != 8'd0) && (r_len != 16'd0) &&
                    (r_len < 16'(sdfc_pkg::DATA_LEN_LIM)) &&
                    (({1'b0, r_len} + 17'(sdfc_pkg::DATA_HDR)) <= TB_17)) begin
                    n_kind     = sdfc_pkg::KIND_DATA;
                    n_gap      = gap;
                    n_missing  = r_missing + {16'd0, gap};
                    n_prev_seq = seq_full;
                    n_seq_seen = 1'b1;
                end
            end
        end else if ((r_kind == sdfc_pkg::KIND_DATA) && (p17 <= data_end)) begin
            is_last   = (p17 == data_end);
            n_run_sum = run_next;
            if (is_last && (run_next != r_rx_sum)) begin
                n_bad = r_bad + 32'd1;
            end
            emit                     = 1'b1;
            n_res.last_in_frame      = is_last;
            n_res.checksum_ok        = is_last && (run_next == r_rx_sum);
            n_res.seq_gap            = r_gap;
            n_res.checksum_bad_total = n_bad;
        end
    end

    always_comb begin
        if (accept) begin
            n_out_valid = emit;
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_status    <= 8'd0;
            r_len       <= 16'd0;
            r_rx_sum    <= 16'd0;
            r_rx_seq    <= 16'd0;
            r_run_sum   <= 16'd0;
            r_prev_seq  <= 16'd0;
            r_seq_seen  <= 1'b0;
            r_missing   <= 32'd0;
            r_bad       <= 32'd0;
            r_kind      <= sdfc_pkg::KIND_NONE;
            r_gap       <= 16'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (accept) begin
                r_pos      <= n_pos;
                r_status   <= n_status;
                r_len      <= n_len;
                r_rx_sum   <= n_rx_sum;
                r_rx_seq   <= n_rx_seq;
                r_run_sum  <= n_run_sum;
                r_prev_seq <= n_prev_seq;
                r_seq_seen <= n_seq_seen;
                r_missing  <= n_missing;
                r_bad      <= n_bad;
                r_kind     <= n_kind;
                r_gap      <= n_gap;
            end
        end
    end

    // The result payload only loads with a new request.
    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid              = r_out_valid;
    assign o_res.payload_byte       = r_res.payload_byte;
    assign o_res.byte_kind          = r_res.byte_kind;
    assign o_res.last_in_frame      = r_res.last_in_frame;
    assign o_res.checksum_ok        = r_res.checksum_ok;
    assign o_res.seq_gap            = r_res.seq_gap;
    assign o_res.seq_missing_total  = r_res.seq_missing_total;
    assign o_res.checksum_bad_total = r_res.checksum_bad_total;

    // A new result only appears as the consequence of an accepted byte.
    a_res_from_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(accept))
        else $error("result appeared without an accepted byte");

    // A checksum verdict belongs only to the last byte of a data frame.
    a_ok_on_last_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.checksum_ok) |-> (r_res.last_in_frame && !r_res.byte_kind))
        else $error("checksum verdict outside the last data byte");

    // Config payload carries no sequence gap and no verdict.
    a_cfg_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.byte_kind) |-> (r_res.seq_gap == 16'd0 && !r_res.checksum_ok))
        else $error("config byte carries data frame status");

    // The mismatch count moves by at most one per byte.
    a_bad_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_bad == $past(r_bad)) || (r_bad == $past(r_bad) + 32'd1))
        else $error("checksum mismatch count jumped");

    // The byte position never passes the transfer length.
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= TB_POS)
        else $error("byte position beyond the transfer");

endmodule

// File: test/sdfc_test_pkg.sv
// Payload tracker for the SPI downlink frame checker test.
// Predicts the payload results of each received byte and checks the block's results.
// Depends on sdfc_pkg.
package sdfc_test_pkg;
    import sdfc_pkg::*;

    class payload_tracker;
        // Register copies.
        bit [7:0]  cfg_code;
        bit [7:0]  cfg_mask;
        bit [8:0]  cfg_limit;

        // Frame parser state.
        int unsigned xfer_bytes;
        int unsigned position;
        bit [7:0]    status;
        bit [15:0]   length;
        bit [15:0]   rx_sum;
        bit [15:0]   rx_seq;
        bit [15:0]   pay_sum;
        bit [15:0]   prev_seq;
        bit          seq_seen;
        bit [31:0]   missing_total;
        bit [31:0]   bad_total;
        t_kind       kind;
        bit [15:0]   gap;

        t_result     pending_payloads[$];
        int unsigned mismatches;

        function new(int unsigned transfer_bytes);
            xfer_bytes    = transfer_bytes;
            cfg_code      = RST_CFG_CODE;
            cfg_mask      = RST_DATA_MASK;
            cfg_limit     = RST_CFG_LIMIT;
            position      = 0;
            status        = '0;
            length        = '0;
            rx_sum        = '0;
            rx_seq        = '0;
            pay_sum       = '0;
            prev_seq      = '0;
            seq_seen      = 1'b0;
            missing_total = '0;
            bad_total     = '0;
            kind          = KIND_NONE;
            gap           = '0;
            mismatches    = 0;
        endfunction

        function void write_register(logic [1:0] index, bit [31:0] value);
            case (index)
                REG_CFG_CODE:  cfg_code  = value[7:0];
                REG_DATA_MASK: cfg_mask  = value[7:0];
                REG_CFG_LIMIT: cfg_limit = value[8:0];
                default: ;
            endcase
        endfunction

        // Advances the parser by one accepted byte and queues the payload result it causes.
        function void take_byte(bit [7:0] value, bit start);
            int unsigned pos;
            bit [15:0]   next_seq;
            bit          last;
            t_result     r;
            pos = (start || position >= xfer_bytes) ? 0 : position;
            position = pos + 1;
            r = '0;
            if (pos == POS_STATUS) begin
                status  = value;
                length  = '0;
                rx_sum  = '0;
                rx_seq  = '0;
                pay_sum = '0;
                kind    = KIND_NONE;
                gap     = '0;
                return;
            end
            if (pos == POS_LEN_HI) begin
                length = {value, 8'h00};
                return;
            end
            if (pos == POS_LEN_LO) begin
                length[7:0] = value;
                if (status == cfg_code && length != 0 && length < cfg_limit &&
                    CFG_HDR + length <= xfer_bytes)
                    kind = KIND_CFG;
                return;
            end
            if (kind == KIND_CFG) begin
                if (pos >= CFG_HDR + length)
                    return;
                r.payload_byte       = value;
                r.byte_kind          = 1'b1;
                r.last_in_frame      = (pos == CFG_HDR + length - 1);
                r.seq_missing_total  = missing_total;
                r.checksum_bad_total = bad_total;
                pending_payloads.push_back(r);
                return;
            end
            if (pos < DATA_HDR) begin
                if (pos == POS_SUM_HI)
                    rx_sum = {value, 8'h00};
                else if (pos == POS_SUM_LO)
                    rx_sum[7:0] = value;
                else if (pos == POS_SEQ_HI)
                    rx_seq = {value, 8'h00};
                else begin
                    rx_seq[7:0] = value;
                    if (status != cfg_code && (status & cfg_mask) != 0 && length != 0 &&
                        length < DATA_LEN_LIM && DATA_HDR + length <= xfer_bytes) begin
                        kind = KIND_DATA;
                        // The sequence is judged here, before any payload of the frame.
                        gap = '0;
                        if (seq_seen) begin
                            next_seq      = prev_seq + 16'd1;
                            gap           = rx_seq - next_seq;
                            missing_total = missing_total + 32'(gap);
                        end
                        prev_seq = rx_seq;
                        seq_seen = 1'b1;
                    end
                end
                return;
            end
            if (kind != KIND_DATA || pos >= DATA_HDR + length)
                return;
            pay_sum = pay_sum + 16'(value);
            last = (pos == DATA_HDR + length - 1);
            if (last && pay_sum != rx_sum)
                bad_total = bad_total + 32'd1;
            r.payload_byte       = value;
            r.byte_kind          = 1'b0;
            r.last_in_frame      = last;
            r.checksum_ok        = last && (pay_sum == rx_sum);
            r.seq_gap            = gap;
            r.seq_missing_total  = missing_total;
            r.checksum_bad_total = bad_total;
            pending_payloads.push_back(r);
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("payload mismatch: %s", what);
        endtask

        task compare_field(string field, longint unsigned got, longint unsigned want);
            if (got != want)
                report_mismatch($sformatf("%s got %0h want %0h", field, got, want));
        endtask

        task check_payload(t_result got);
            t_result want;
            if (pending_payloads.size() == 0) begin
                report_mismatch($sformatf("result %0h with nothing outstanding",
                                          got.payload_byte));
                return;
            end
            want = pending_payloads.pop_front();
            compare_field("payload_byte", got.payload_byte, want.payload_byte);
            compare_field("byte_kind", got.byte_kind, want.byte_kind);
            compare_field("last_in_frame", got.last_in_frame, want.last_in_frame);
            compare_field("checksum_ok", got.checksum_ok, want.checksum_ok);
            compare_field("seq_gap", got.seq_gap, want.seq_gap);
            compare_field("seq_missing_total", got.seq_missing_total, want.seq_missing_total);
            compare_field("checksum_bad_total", got.checksum_bad_total,
                          want.checksum_bad_total);
        endtask
    endclass

endpackage

// File: test/spi_downlink_frame_checker_test.sv
// Top-level test of the SPI downlink frame checker.
// Drives framed SPI bytes and register writes, checks every payload result.
// Depends on sdfc_pkg, sdfc_if.sv, the RTL and sdfc_test_pkg.
module spi_downlink_frame_checker_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sdfc_pkg::*;
    import sdfc_test_pkg::*;

    localparam int unsigned XFER_BYTES    = 512;
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned PHASE_ITEMS   = 180;
    localparam int unsigned FIRST_GOAL    = 1000;

    // Receiver stall patterns.
    typedef enum int unsigned {
        STALL_NONE,
        STALL_COIN,
        STALL_PERIODIC,
        STALL_LIGHT
    } t_stall;

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    sdfc_rx_if  rx_ch ();
    sdfc_res_if res_ch ();

    payload_tracker tracker = new(XFER_BYTES);

    // Sender burst bookkeeping and the handshake with the receiver process.
    int unsigned burst_left = 0;
    int unsigned bytes_sent = 0;
    bit          hold_request = 1'b0;

    spi_downlink_frame_checker #(
        .TRANSFER_BYTES(XFER_BYTES)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Sends one byte as one request. The sender works in bursts: when a burst
    // is used up, valid drops for a random gap and a new burst length is drawn.
    // Occasionally a burst is long, giving stretches with no idling at all.
    task automatic send_byte(bit [7:0] value, bit start);
        int unsigned gap;
        if (burst_left == 0) begin
            rx_ch.valid <= 1'b0;
            gap = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(7) == 0) ? $urandom_range(100, 200)
                                                   : $urandom_range(1, 24);
        end
        rx_ch.valid          <= 1'b1;
        rx_ch.rx_byte        <= value;
        rx_ch.transfer_start <= start;
        do @(posedge i_clk); while (rx_ch.ready !== 1'b1);
        tracker.take_byte(value, start);
        burst_left--;
        bytes_sent++;
    endtask

    // Sends a frame: status, big-endian length, then for the data layout the
    // checksum and sequence number, then `tail` body bytes. A tail shorter than
    // the length leaves the frame unfinished; a longer one adds trailing bytes
    // that the block must ignore. The checksum covers the body up to the length.
    task automatic send_frame(bit data_layout, bit [7:0] status, bit [15:0] len,
                              bit [15:0] seq, bit sum_ok, int unsigned tail, bit lead_start);
        bit [7:0]    body[$];
        bit [15:0]   sum;
        int unsigned i;
        sum = '0;
        for (i = 0; i < tail; i++) begin
            body.push_back(8'($urandom()));
            if (i < len)
                sum = sum + 16'(body[i]);
        end
        if (!sum_ok)
            sum = sum ^ 16'($urandom_range(1, 65535));
        send_byte(status, lead_start);
        send_byte(len[15:8], 1'b0);
        send_byte(len[7:0], 1'b0);
        if (data_layout) begin
            send_byte(sum[15:8], 1'b0);
            send_byte(sum[7:0], 1'b0);
            send_byte(seq[15:8], 1'b0);
            send_byte(seq[7:0], 1'b0);
        end
        foreach (body[k])
            send_byte(body[k], 1'b0);
    endtask

    // Picks one random frame. Most are well formed config or data frames under
    // the current register settings, so that the payload path is exercised
    // deeply; the rest are lengths at the acceptance edges, empty frames,
    // unfinished frames, frames without a transfer start and plain noise.
    task automatic random_frame();
        bit [7:0]    status;
        bit [15:0]   len;
        bit [15:0]   seq;
        int unsigned tail;
        int unsigned roll;
        int unsigned bitpos;
        roll = $urandom_range(99);
        if (roll < 5) begin
            repeat ($urandom_range(1, 10))
                send_byte(8'($urandom()), $urandom_range(3) == 0);
            return;
        end
        if (roll < 38) begin
            status = tracker.cfg_code;
        end else if (roll < 85) begin
            // Force at least one bit of the data mask on, when the mask has any.
            status = 8'($urandom());
            if (tracker.cfg_mask != 0) begin
                do bitpos = $urandom_range(7); while (!tracker.cfg_mask[bitpos]);
                status[bitpos] = 1'b1;
            end
        end else begin
            status = 8'($urandom());
        end

        roll = $urandom_range(99);
        if (roll < 80) begin
            len = 16'($urandom_range(1, 12));
        end else if (roll < 86) begin
            len = '0;
        end else if (roll < 94) begin
            case ($urandom_range(5))
                0: len = 16'(tracker.cfg_limit) - 16'd1;
                1: len = 16'(tracker.cfg_limit);
                2: len = 16'(XFER_BYTES - DATA_HDR);
                3: len = 16'(XFER_BYTES - DATA_HDR + 1);
                4: len = 16'(DATA_LEN_LIM - 1);
                default: len = 16'(DATA_LEN_LIM);
            endcase
        end else begin
            len = 16'($urandom());
        end

        roll = $urandom_range(99);
        if (roll < 60)
            seq = tracker.prev_seq + 16'd1;
        else if (roll < 75)
            seq = tracker.prev_seq + 16'($urandom_range(2, 9));
        else if (roll < 82)
            seq = tracker.prev_seq;
        else
            seq = 16'($urandom());

        // Long frames only send their header and a few bytes; the full-size
        // frames are sent on purpose elsewhere.
        if (len <= 40) begin
            roll = $urandom_range(99);
            if (roll < 70)
                tail = len;
            else if (roll < 85)
                tail = len + $urandom_range(1, 5);
            else
                tail = $urandom_range(len);
        end else begin
            tail = $urandom_range(8);
        end

        send_frame(status != tracker.cfg_code, status, len, seq, $urandom_range(3) != 0,
                   tail, $urandom_range(19) != 0);
    endtask

    // Stops the sender and waits until every predicted result has come out,
    // plus a few cycles for frames that are still being parsed.
    task automatic wait_idle();
        rx_ch.valid <= 1'b0;
        burst_left = 0;
        while (tracker.pending_payloads.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One register write: a setup cycle, then an access cycle that completes
    // at the edge where pready is high. Afterwards the bus is left idle.
    task automatic reg_write(logic [1:0] index, bit [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        tracker.write_register(index, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Every accepted result is checked against the oldest prediction.
    always @(posedge i_clk) begin : res_monitor
        t_result seen;
        if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            seen.payload_byte       = res_ch.payload_byte;
            seen.byte_kind          = res_ch.byte_kind;
            seen.last_in_frame      = res_ch.last_in_frame;
            seen.checksum_ok        = res_ch.checksum_ok;
            seen.seq_gap            = res_ch.seq_gap;
            seen.seq_missing_total  = res_ch.seq_missing_total;
            seen.checksum_bad_total = res_ch.checksum_bad_total;
            tracker.check_payload(seen);
        end
    end

    // The receiver runs its own stall patterns in segments of random length.
    // When asked, it holds off for a long stretch while the sender keeps going,
    // so the output register fills and the block has to stall its input.
    initial begin : res_stall
        int unsigned seg_left;
        int unsigned period;
        int unsigned tick;
        t_stall      mode;
        seg_left = 0;
        period   = 1;
        tick     = 0;
        mode     = STALL_NONE;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_request = 1'b0;
                seg_left = 0;
            end else begin
                if (seg_left == 0) begin
                    mode     = t_stall'($urandom_range(3));
                    seg_left = $urandom_range(20, 200);
                    period   = $urandom_range(2, 5);
                    tick     = 0;
                end
                case (mode)
                    STALL_NONE:     res_ch.ready <= 1'b1;
                    STALL_COIN:     res_ch.ready <= 1'($urandom_range(1));
                    STALL_PERIODIC: res_ch.ready <= (tick % period == 0);
                    default:        res_ch.ready <= ($urandom_range(7) != 0);
                endcase
                seg_left--;
                tick++;
            end
        end
    end

    // Cycle limit for the whole run.
    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin : stimulus
        bit [7:0] phase_code[5];
        bit [7:0] phase_mask[5];
        bit [8:0] phase_limit[5];
        int       p;

        // Settings after the reset defaults: the config code sharing the data
        // mask bit with the smallest legal limit, status zero as config code with
        // every status bit marking data and the widest limit, a limit of zero
        // that shuts out config frames, a zero mask that shuts out data frames,
        // and finally the defaults written back.
        phase_code  = '{8'h80, 8'h00, 8'hFF, 8'h5A, 8'h01};
        phase_mask  = '{8'h80, 8'hFF, 8'h01, 8'h00, 8'h80};
        phase_limit = '{9'd2, 9'd511, 9'd0, 9'd256, 9'd256};

        rx_ch.valid          <= 1'b0;
        rx_ch.rx_byte        <= '0;
        rx_ch.transfer_start <= 1'b0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        i_rst_n              <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames under the reset settings. The smallest config frame,
        // then the first data frame (no sequence history, so no gap), then a
        // data frame with every status bit set, a wrong checksum and a sequence
        // far ahead, then a data frame cut short by the next transfer start.
        send_frame(1'b0, 8'h01, 16'd1, 16'h0000, 1'b1, 1, 1'b1);
        send_frame(1'b1, 8'h80, 16'd1, 16'h0000, 1'b1, 1, 1'b1);
        send_frame(1'b1, 8'hFF, 16'd1, 16'hFFFF, 1'b0, 1, 1'b1);
        send_frame(1'b1, 8'h80, 16'd4, 16'h0000, 1'b1, 1, 1'b1);

        // The largest data frame fills the transfer exactly, so the next frame
        // begins by transfer overrun without a transfer start.
        send_frame(1'b1, 8'h80, 16'(XFER_BYTES - DATA_HDR), tracker.prev_seq + 16'd1,
                   1'b1, XFER_BYTES - DATA_HDR, 1'b1);
        send_frame(1'b1, 8'h80, 16'd2, tracker.prev_seq + 16'd1, 1'b1, 2, 1'b0);
        // The longest config frame the default limit admits.
        send_frame(1'b0, 8'h01, 16'(RST_CFG_LIMIT) - 16'd1, 16'h0000, 1'b1,
                   RST_CFG_LIMIT - 1, 1'b1);

        while (bytes_sent < FIRST_GOAL)
            random_frame();

        for (p = 0; p < 5; p++) begin
            wait_idle();
            reg_write(REG_CFG_CODE, 32'(phase_code[p]));
            reg_write(REG_DATA_MASK, 32'(phase_mask[p]));
            reg_write(REG_CFG_LIMIT, 32'(phase_limit[p]));
            if (p == 0 || p == 2)
                hold_request = 1'b1;
            while (bytes_sent < FIRST_GOAL + PHASE_ITEMS * (p + 1))
                random_frame();
        end

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (tracker.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
